>>> rtl/box_filter_downsampler_core_macros.svh
// ----------------------------------------------------------------------------
// Box filter downsampler - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_DOWNSAMPLER_CORE_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLER_CORE_MACROS_SVH

// Next-cycle implication, off while reset is high.
`define BFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box filter downsampler: check failed");

// Next-cycle implication that also holds across reset.
`define BFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("box filter downsampler: check failed");

`endif

>>> rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - package
// Shared widths, register map, reset values and inter-module types.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int PIX_W         = 16;   // 8.8 color channel
  localparam int SUM_W         = 24;   // per-column channel sum
  localparam int POS_W         = 11;   // output column / row
  localparam int SCALE_CFG_W   = 5;
  localparam int DIM_CFG_W     = 12;
  localparam int RECIP_W       = 17;   // 1.16 reciprocal, up to 1.0
  localparam int FRAC_W        = 16;
  localparam int DATA_W        = 32;
  localparam int PADDR_W       = 4;
  localparam int MAX_HEIGHT    = 2048;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_SCALE = 16;

  localparam logic [SCALE_CFG_W-1:0] RST_BLOCK_SCALE = 5'd2;
  localparam logic [DIM_CFG_W-1:0]   RST_SRC_WIDTH   = 12'd640;
  localparam logic [DIM_CFG_W-1:0]   RST_SRC_HEIGHT  = 12'd480;
  localparam logic [RECIP_W-1:0]     RST_AREA_RECIP  = 17'd16384;

  typedef enum logic [1:0] {
    REG_BLOCK_SCALE = 2'd0,
    REG_SRC_WIDTH   = 2'd1,
    REG_SRC_HEIGHT  = 2'd2,
    REG_AREA_RECIP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SCALE_CFG_W-1:0] block_scale;
    logic [DIM_CFG_W-1:0]   src_width;
    logic [DIM_CFG_W-1:0]   src_height;
    logic [RECIP_W-1:0]     area_reciprocal;
  } cfg_t;

  // Per-pixel control decided by the raster counters.
  typedef struct packed {
    logic             fresh;      // first pixel row of a block row: overwrite sum
    logic             emit;       // bottom-right pixel of a block
    logic             frame_end;  // last complete block of the frame
    logic [POS_W-1:0] row;        // output row of the block
  } item_ctl_t;

endpackage

>>> rtl/bfd_ram.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bfd_regs.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - configuration registers
// APB-style register file; flags writes of the block scale.
// ----------------------------------------------------------------------------
module bfd_regs import bfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg,
  output logic               scale_wr
);

  reg_idx_t reg_sel;
  logic     wr;

  assign reg_sel  = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr       = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign scale_wr = wr && (reg_sel == REG_BLOCK_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_scale     <= RST_BLOCK_SCALE;
      cfg.src_width       <= RST_SRC_WIDTH;
      cfg.src_height      <= RST_SRC_HEIGHT;
      cfg.area_reciprocal <= RST_AREA_RECIP;
    end else if (wr) begin
      unique case (reg_sel)
        REG_BLOCK_SCALE: cfg.block_scale     <= pwdata[SCALE_CFG_W-1:0];
        REG_SRC_WIDTH:   cfg.src_width       <= pwdata[DIM_CFG_W-1:0];
        REG_SRC_HEIGHT:  cfg.src_height      <= pwdata[DIM_CFG_W-1:0];
        REG_AREA_RECIP:  cfg.area_reciprocal <= pwdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_SCALE: prdata = DATA_W'(cfg.block_scale);
      REG_SRC_WIDTH:   prdata = DATA_W'(cfg.src_width);
      REG_SRC_HEIGHT:  prdata = DATA_W'(cfg.src_height);
      REG_AREA_RECIP:  prdata = DATA_W'(cfg.area_reciprocal);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/bfd_scan.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - raster scan counters
// Tracks source position and block phase; output row kept as quotient and
// remainder, re-derived by a bit-serial divider when the scale changes.
// ----------------------------------------------------------------------------
module bfd_scan import bfd_pkg::*; #(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int  MAX_SCALE = DEF_MAX_SCALE,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             scale_wr,
  input  logic             take,
  output logic [COL_W-1:0] idx,
  output item_ctl_t        ctl,
  output logic             busy
);

  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int SCL_W     = $clog2(MAX_SCALE + 1);
  localparam int SC_CMP_W  = (SCL_W > SCALE_CFG_W) ? SCL_W : SCALE_CFG_W;
  localparam int WD_CMP_W  = (WID_W > DIM_CFG_W) ? WID_W : DIM_CFG_W;
  localparam int LC_W      = ((WID_W > SCL_W) ? WID_W : SCL_W) + 1;
  localparam int LR_W      = ((DIM_CFG_W > SCL_W) ? DIM_CFG_W : SCL_W) + 1;
  localparam int ROW_W     = POS_W;
  localparam int DIV_CNT_W = $clog2(ROW_W + 1);

  logic [COL_W-1:0]     src_col;
  logic [COL_W-1:0]     dst_col;
  logic [ROW_W-1:0]     src_row;
  logic [ROW_W-1:0]     dst_row;
  logic [SCL_W-1:0]     row_rem;
  logic [SCL_W-1:0]     sub_col;
  logic [SCL_W-1:0]     sub_row;
  logic [ROW_W-1:0]     div_num;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [SC_CMP_W-1:0]  bs_x;
  logic [WD_CMP_W-1:0]  bw_x;
  logic [SCL_W-1:0]     scale;
  logic [WID_W-1:0]     eff_width;
  logic [DIM_CFG_W-1:0] eff_height;
  logic                 col_done;
  logic                 row_done;
  logic                 line_end;
  logic                 row_end;
  logic                 last_col;
  logic                 last_row;
  logic                 rem_wrap;
  logic [SCL_W:0]       div_t;
  logic                 div_ge;

  // Clamp the configuration into usable ranges.
  always_comb begin
    bs_x = SC_CMP_W'(cfg.block_scale);
    bw_x = WD_CMP_W'(cfg.src_width);
    if (cfg.block_scale == '0) begin
      scale = SCL_W'(1);
    end else if (bs_x > SC_CMP_W'(MAX_SCALE)) begin
      scale = SCL_W'(MAX_SCALE);
    end else begin
      scale = SCL_W'(bs_x);
    end
    if (cfg.src_width == '0) begin
      eff_width = WID_W'(1);
    end else if (bw_x > WD_CMP_W'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = WID_W'(bw_x);
    end
    if (cfg.src_height == '0) begin
      eff_height = DIM_CFG_W'(1);
    end else if (cfg.src_height > DIM_CFG_W'(MAX_HEIGHT)) begin
      eff_height = DIM_CFG_W'(MAX_HEIGHT);
    end else begin
      eff_height = cfg.src_height;
    end
  end

  assign col_done = (SCL_W+1)'(sub_col) + (SCL_W+1)'(1) >= (SCL_W+1)'(scale);
  assign row_done = (SCL_W+1)'(sub_row) + (SCL_W+1)'(1) >= (SCL_W+1)'(scale);
  assign rem_wrap = (SCL_W+1)'(row_rem) + (SCL_W+1)'(1) >= (SCL_W+1)'(scale);
  assign line_end = WID_W'(src_col) + WID_W'(1) >= eff_width;
  assign row_end  = DIM_CFG_W'(src_row) + DIM_CFG_W'(1) >= eff_height;
  assign last_col = LC_W'(src_col) + LC_W'(1) + LC_W'(scale) > LC_W'(eff_width);
  assign last_row = LR_W'(src_row) + LR_W'(1) + LR_W'(scale) > LR_W'(eff_height);

  assign idx           = dst_col;
  assign ctl.fresh     = (sub_row == '0);
  assign ctl.emit      = col_done && row_done;
  assign ctl.frame_end = last_col && last_row;
  assign ctl.row       = dst_row;
  assign busy          = (div_cnt != '0);

  // Restoring divide step: remainder stays below scale.
  assign div_t  = {row_rem, div_num[ROW_W-1]};
  assign div_ge = div_t >= (SCL_W+1)'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      dst_col <= '0;
      src_row <= '0;
      dst_row <= '0;
      row_rem <= '0;
      sub_col <= '0;
      sub_row <= '0;
      div_num <= '0;
      div_cnt <= '0;
    end else if (scale_wr) begin
      div_num <= src_row;
      dst_row <= '0;
      row_rem <= '0;
      div_cnt <= DIV_CNT_W'(ROW_W);
    end else if (busy) begin
      row_rem <= div_ge ? SCL_W'(div_t - (SCL_W+1)'(scale)) : SCL_W'(div_t);
      dst_row <= {dst_row[ROW_W-2:0], div_ge};
      div_num <= div_num << 1;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end else if (take) begin
      if (line_end) begin
        src_col <= '0;
        sub_col <= '0;
        dst_col <= '0;
        if (row_end) begin
          src_row <= '0;
          sub_row <= '0;
          dst_row <= '0;
          row_rem <= '0;
        end else begin
          src_row <= src_row + ROW_W'(1);
          sub_row <= row_done ? '0 : sub_row + SCL_W'(1);
          if (rem_wrap) begin
            row_rem <= '0;
            dst_row <= dst_row + ROW_W'(1);
          end else begin
            row_rem <= row_rem + SCL_W'(1);
          end
        end
      end else begin
        src_col <= src_col + COL_W'(1);
        if (col_done) begin
          sub_col <= '0;
          dst_col <= dst_col + COL_W'(1);
        end else begin
          sub_col <= sub_col + SCL_W'(1);
        end
      end
    end
  end

endmodule

>>> rtl/bfd_datapath.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - accumulate and average datapath
// Column sum read-modify-write with forwarding, reciprocal multiply,
// output register. Clears the sum memory after reset.
// ----------------------------------------------------------------------------
module bfd_datapath import bfd_pkg::*; #(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [PIX_W-1:0]   in_red,
  input  logic [PIX_W-1:0]   in_green,
  input  logic [PIX_W-1:0]   in_blue,
  input  logic [COL_W-1:0]   idx,
  input  item_ctl_t          ctl,
  input  logic [RECIP_W-1:0] recip,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_red,
  output logic [PIX_W-1:0]   out_green,
  output logic [PIX_W-1:0]   out_blue,
  output logic [POS_W-1:0]   out_col,
  output logic [POS_W-1:0]   out_row,
  output logic               frame_end
);

  localparam int LANES  = 3;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic                           clr_busy;
  logic [COL_W-1:0]               clr_addr;

  logic                           s1_valid;
  logic [COL_W-1:0]               s1_idx;
  logic [LANES-1:0][PIX_W-1:0]    s1_pix;
  item_ctl_t                      s1_ctl;
  logic                           s1_fwd;
  logic [LANES-1:0][SUM_W-1:0]    s1_fwd_sum;

  logic                           s2_valid;
  logic [LANES-1:0][SUM_W-1:0]    s2_sum;
  logic [POS_W-1:0]               s2_col;
  logic [POS_W-1:0]               s2_row;
  logic                           s2_fe;

  logic [LANES-1:0][SUM_W-1:0]    rd_sum;
  logic [LANES-1:0][SUM_W-1:0]    old_sum;
  logic [LANES-1:0][SUM_W-1:0]    new_sum;
  logic [LANES-1:0][SUM_W:0]      add_sum;
  logic [LANES-1:0][PROD_W-1:0]   prod;
  logic [LANES-1:0][PIX_W-1:0]    avg;

  logic                           out_go;
  logic                           s2_go;
  logic                           s2_free;
  logic                           s1_go;
  logic                           ram_we;
  logic [COL_W-1:0]               ram_waddr;
  logic [LANES*SUM_W-1:0]         ram_wdata;

  // Handshake between stages: each stage moves on when the next has room.
  assign out_go  = !out_valid || !out_stall;
  assign s2_go   = s2_valid && out_go;
  assign s2_free = !s2_valid || out_go;
  assign s1_go   = s1_valid && (!s1_ctl.emit || s2_free);
  assign ready   = !clr_busy && (!s1_valid || s1_go);

  // Saturating accumulate; the first row of a block row overwrites.
  always_comb begin
    old_sum = s1_fwd ? s1_fwd_sum : rd_sum;
    for (int k = 0; k < LANES; k++) begin
      add_sum[k] = (SUM_W+1)'(old_sum[k]) + (SUM_W+1)'(s1_pix[k]);
      if (s1_ctl.fresh) begin
        new_sum[k] = SUM_W'(s1_pix[k]);
      end else if (add_sum[k][SUM_W]) begin
        new_sum[k] = '1;
      end else begin
        new_sum[k] = add_sum[k][SUM_W-1:0];
      end
    end
  end

  // Average = sum * reciprocal >> 16, saturated to 16 bits.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod[k] = PROD_W'(s2_sum[k]) * PROD_W'(recip);
      if (prod[k][PROD_W-1:FRAC_W+PIX_W] != '0) begin
        avg[k] = '1;
      end else begin
        avg[k] = prod[k][FRAC_W+PIX_W-1:FRAC_W];
      end
    end
  end

  assign ram_we    = clr_busy || s1_go;
  assign ram_waddr = clr_busy ? clr_addr : s1_idx;
  assign ram_wdata = clr_busy ? '0 : new_sum;

  bfd_ram #(
    .WIDTH (LANES * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (idx),
    .rdata (rd_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + COL_W'(1);
        if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_ctl.emit) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_idx     <= idx;
      s1_pix     <= {in_red, in_green, in_blue};
      s1_ctl     <= ctl;
      // Same column written back this edge: RAM read is stale, forward.
      s1_fwd     <= s1_go && (s1_idx == idx);
      s1_fwd_sum <= new_sum;
    end
    if (s1_go && s1_ctl.emit) begin
      s2_sum <= new_sum;
      s2_col <= POS_W'(s1_idx);
      s2_row <= s1_ctl.row;
      s2_fe  <= s1_ctl.frame_end;
    end
    if (s2_go) begin
      out_red   <= avg[2];
      out_green <= avg[1];
      out_blue  <= avg[0];
      out_col   <= s2_col;
      out_row   <= s2_row;
      frame_end <= s2_fe;
    end
  end

endmodule

>>> rtl/box_filter_downsampler_core.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - top level
// Averages each block_scale x block_scale block of a raster RGB stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one source pixel per transfer in
//    raster order, channels in unsigned 8.8.
//  - Output channel (out_valid / out_stall): one averaged pixel per completed
//    block, with its column, row and a frame_end flag on the frame's last one.
//  - Throughput: one pixel per cycle unless stalled, set by the single
//    read-modify-write of the column-sum memory (one read port, one write
//    port, with forwarding). Results pass the s1, s2 and output registers.
//  - Reset: counters return to the frame origin and the column-sum memory is
//    cleared, one entry per cycle over all MAX_WIDTH entries; in_stall is
//    high during that sweep. Registers can be written meanwhile.
//  - A write of block_scale re-derives the output row from the source row
//    with a bit-serial divider; in_stall is high while it runs.
//  - When the receiver stalls, the result holds in the output register while
//    pixels that close no block keep flowing; in_stall rises only once a
//    further block result has nowhere to go.
//  - Configuration is written over the APB port between frames or while the
//    block is idle.
// ----------------------------------------------------------------------------
module box_filter_downsampler_core import bfd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic               clk,
  input  logic               rst,
  // source pixels
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_red,
  input  logic [PIX_W-1:0]   in_green,
  input  logic [PIX_W-1:0]   in_blue,
  // averaged pixels
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_red,
  output logic [PIX_W-1:0]   out_green,
  output logic [PIX_W-1:0]   out_blue,
  output logic [POS_W-1:0]   out_col,
  output logic [POS_W-1:0]   out_row,
  output logic               frame_end,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  cfg_t             cfg;
  logic             scale_wr;
  logic             take;
  logic             dp_ready;
  logic             scan_busy;
  logic [COL_W-1:0] idx;
  item_ctl_t        ctl;

  // A transfer is taken only when the datapath has room and the row
  // divider is not re-deriving the output row.
  assign in_stall = !dp_ready || scan_busy;
  assign take     = in_valid && !in_stall;

  bfd_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .scale_wr (scale_wr)
  );

  // Raster position, block phase and per-pixel control.
  bfd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .scale_wr (scale_wr),
    .take     (take),
    .idx      (idx),
    .ctl      (ctl),
    .busy     (scan_busy)
  );

  // Column sums, averaging and the output register.
  bfd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .idx       (idx),
    .ctl       (ctl),
    .recip     (cfg.area_reciprocal),
    .ready     (dp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_col   (out_col),
    .out_row   (out_row),
    .frame_end (frame_end)
  );

endmodule

>>> rtl/bfd_port_check.sv
// ----------------------------------------------------------------------------
// Box filter downsampler - port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "box_filter_downsampler_core_macros.svh"

module bfd_port_check import bfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PIX_W-1:0]   out_red,
  input logic [PIX_W-1:0]   out_green,
  input logic [PIX_W-1:0]   out_blue,
  input logic [POS_W-1:0]   out_col,
  input logic [POS_W-1:0]   out_row,
  input logic               frame_end,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr
);

  // Reset empties the output and starts the memory sweep.
  `BFD_ASSERT_NEXT_ALWAYS(a_rst_no_out, clk, rst, !out_valid)
  `BFD_ASSERT_NEXT_ALWAYS(a_rst_sweep, clk, rst, in_stall)

  // A scale write must hold off pixels while the row is re-derived.
  `BFD_ASSERT_NEXT(a_scale_wr_stall, clk, rst, psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_BLOCK_SCALE), in_stall)

  // Output channel holds while stalled.
  `BFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `BFD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_col) && $stable(out_row) && $stable(frame_end))

endmodule

bind box_filter_downsampler_core bfd_port_check u_port_check (.*);
